@@ rtl/sdn_pkg.sv @@
// Shared types, widths and helpers for the box signed-distance unit.
// Used by every module in rtl/; depends on nothing.
package sdn_pkg;

    localparam int POS_W  = 32;
    localparam int RAD_W  = 31;
    localparam int CLR_W  = 35;
    localparam int MAG_W  = 31;
    localparam int SQ_W   = 62;
    localparam int SUM_W  = 64;
    localparam int ROOT_W = 32;
    localparam int REM_W  = 35;
    localparam int LEN_W  = 33;
    localparam int Q_W    = 15;
    localparam int NUM_W  = 47;
    localparam int DEN_W  = 34;
    localparam int NRM_W  = 16;
    localparam int DIST_W = 32;
    localparam int CFG_IDX_W = 3;

    localparam int SQRT_LAT = ROOT_W;
    localparam int DIV_LAT  = Q_W;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic signed [NRM_W-1:0] NRM_ONE = 16'sd16384;

    typedef enum logic [1:0] {
        REG_INSIDE = 2'd0,
        REG_FACE   = 2'd1,
        REG_EDGE   = 2'd2
    } t_region;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_X = 3'd0,
        CFG_MIN_Y = 3'd1,
        CFG_MIN_Z = 3'd2,
        CFG_MAX_X = 3'd3,
        CFG_MAX_Y = 3'd4,
        CFG_MAX_Z = 3'd5,
        CFG_SIGN  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [RAD_W-1:0]        radius;
    } t_in_word;

    typedef struct packed {
        logic signed [DIST_W-1:0] distance;
        logic signed [NRM_W-1:0]  normal_x;
        logic signed [NRM_W-1:0]  normal_y;
        logic signed [NRM_W-1:0]  normal_z;
        logic                     inside_res;
        logic [1:0]               region;
    } t_out_word;

    typedef struct packed {
        logic [2:0][POS_W-1:0] box_min;
        logic [2:0][POS_W-1:0] box_max;
        logic                  sign_negative;
    } t_cfg;

    // One classified query on its way from front to back.
    typedef struct packed {
        t_region                 region;
        logic                    in_box;
        logic                    sneg;
        logic                    ksat;
        logic [2:0]              neg;
        logic [DIST_W-1:0]       dval;
        logic [2:0][NRM_W-1:0]   nrm;
        logic [2:0][MAG_W-1:0]   mag;
    } t_job;

    function automatic logic [DIST_W-1:0] sat_dist(input logic signed [CLR_W:0] v);
        logic [DIST_W-1:0] r;
        if (v > 36'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -36'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[DIST_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/aabb_signed_distance_normal_unit.sv @@
// Top level of the box signed-distance unit: configuration registers and wiring.
// Depends on sdn_pkg, sdn_front, sdn_queue and sdn_back.
//
// Signed distance from a sphere (point plus radius, Q15.16) to an axis-aligned
// box held in configuration, with the normal (Q1.14) of the nearest feature.
// Inside the box the smallest face clearance is reported, outside past one
// face that face's clearance, and near an edge or corner the negated length of
// the overshoot vector with its unit direction; the sign register flips both.
// The unit takes one word per cycle while o_in_stall is low; its latency is set
// mostly by the back end's 32-stage square root and 15-stage normal dividers. A
// short queue sits between the two-stage classifying front and the back end,
// so either side can stall alone. Output stall freezes the back pipeline; the
// queue and front keep filling until full. Write configuration only while idle.
module aabb_signed_distance_normal_unit #(
    parameter int QUEUE_DEPTH = sdn_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  sdn_pkg::t_in_word               i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output sdn_pkg::t_out_word              o_out_word,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sdn_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sdn_pkg::POS_W-1:0]       i_cfg_data
);
    import sdn_pkg::*;

    t_cfg  r_cfg;
    logic  push, full, q_valid, pop;
    t_job  front_job, q_job;

    assign o_cfg_ready = 1'b1;

    // Register file; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.box_min       <= '0;
            r_cfg.box_max       <= {3{32'd65536}};
            r_cfg.sign_negative <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MIN_X: r_cfg.box_min[0] <= i_cfg_data;
                CFG_MIN_Y: r_cfg.box_min[1] <= i_cfg_data;
                CFG_MIN_Z: r_cfg.box_min[2] <= i_cfg_data;
                CFG_MAX_X: r_cfg.box_max[0] <= i_cfg_data;
                CFG_MAX_Y: r_cfg.box_max[1] <= i_cfg_data;
                CFG_MAX_Z: r_cfg.box_max[2] <= i_cfg_data;
                CFG_SIGN:  r_cfg.sign_negative <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    sdn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_word  (i_in_word),
        .i_cfg   (r_cfg),
        .o_push  (push),
        .i_full  (full),
        .o_job   (front_job)
    );

    sdn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_job)
    );

    sdn_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (q_job),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_word  (o_out_word)
    );

endmodule

@@ rtl/sdn_front.sv @@
// Front end: forms the six face clearances and classifies each query.
// Depends on sdn_pkg.
module sdn_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  sdn_pkg::t_in_word i_word,
    input  sdn_pkg::t_cfg   i_cfg,
    output logic            o_push,
    input  logic            i_full,
    output sdn_pkg::t_job   o_job
);
    import sdn_pkg::*;

    logic                           en;
    logic                           r_a_vld;
    logic                           r_a_sneg;
    logic signed [CLR_W-1:0]        r_clr [6];
    logic                           r_b_vld;
    t_job                           r_job;
    t_job                           n_job;
    logic [POS_W-1:0]               pos [3];

    assign en      = !(r_b_vld && i_full);
    assign o_stall = !en;
    assign o_push  = r_b_vld && !i_full;
    assign o_job   = r_job;

    assign pos[0] = i_word.pos_x;
    assign pos[1] = i_word.pos_y;
    assign pos[2] = i_word.pos_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_sneg <= i_cfg.sign_negative;
            for (int a = 0; a < 3; a++) begin
                r_clr[2*a] <= CLR_W'($signed(pos[a])) - CLR_W'($signed({1'b0, i_word.radius}))
                              - CLR_W'($signed(i_cfg.box_min[a]));
                r_clr[2*a+1] <= CLR_W'($signed(i_cfg.box_max[a])) - CLR_W'($signed(pos[a]))
                                - CLR_W'($signed({1'b0, i_word.radius}));
            end
            r_job <= n_job;
        end
    end

    // Classification of the registered clearances.
    always_comb begin
        logic [5:0]                neg6;
        logic [2:0]                cnt;
        logic [2:0]                last;
        logic [2:0]                p0, p1, p2, pa, best, sel;
        logic signed [CLR_W-1:0]   v0, v1, v2, va, cs;
        logic signed [CLR_W:0]     sd;
        logic [CLR_W-2:0]          m;
        logic [2:0][CLR_W-2:0]     mag;
        logic                      fit0, fit1;
        logic [1:0]                k;

        n_job = '0;
        for (int i = 0; i < 6; i++) neg6[i] = r_clr[i][CLR_W-1];
        cnt  = 3'($countones(neg6));
        last = 3'd0;
        for (int i = 0; i < 6; i++) if (neg6[i]) last = 3'(i);

        // Smallest clearance, the later face taking a tie.
        p0 = (r_clr[1] <= r_clr[0]) ? 3'd1 : 3'd0;
        v0 = (r_clr[1] <= r_clr[0]) ? r_clr[1] : r_clr[0];
        p1 = (r_clr[3] <= r_clr[2]) ? 3'd3 : 3'd2;
        v1 = (r_clr[3] <= r_clr[2]) ? r_clr[3] : r_clr[2];
        p2 = (r_clr[5] <= r_clr[4]) ? 3'd5 : 3'd4;
        v2 = (r_clr[5] <= r_clr[4]) ? r_clr[5] : r_clr[4];
        pa = (v1 <= v0) ? p1 : p0;
        va = (v1 <= v0) ? v1 : v0;
        best = (v2 <= va) ? p2 : pa;

        sel = (neg6 == 6'd0) ? best : last;
        cs  = r_clr[sel];
        sd  = r_a_sneg ? -(CLR_W+1)'(cs) : (CLR_W+1)'(cs);

        if (neg6 == 6'd0)  n_job.region = REG_INSIDE;
        else if (cnt == 3'd1) n_job.region = REG_FACE;
        else               n_job.region = REG_EDGE;
        n_job.in_box = (neg6 == 6'd0);
        n_job.sneg   = r_a_sneg;
        n_job.dval   = sat_dist(sd);
        n_job.nrm[sel[2:1]] = (sel[0] ^ r_a_sneg) ? -NRM_ONE : NRM_ONE;

        // Overshoot vector: the min face wins when both faces of an axis are out.
        for (int a = 0; a < 3; a++) begin
            m = '0;
            if (neg6[2*a]) begin
                m = (CLR_W-1)'(-r_clr[2*a]);
            end else if (neg6[2*a+1]) begin
                m = (CLR_W-1)'(-r_clr[2*a+1]);
            end
            mag[a]         = m;
            n_job.neg[a]   = neg6[2*a];
        end
        fit0 = 1'b1;
        fit1 = 1'b1;
        for (int a = 0; a < 3; a++) begin
            if (mag[a][CLR_W-2:MAG_W] != '0)   fit0 = 1'b0;
            if (mag[a][CLR_W-2:MAG_W+1] != '0) fit1 = 1'b0;
        end
        k = fit0 ? 2'd0 : (fit1 ? 2'd1 : 2'd2);
        n_job.ksat = !fit0;
        for (int a = 0; a < 3; a++) n_job.mag[a] = MAG_W'(mag[a] >> k);
    end

endmodule

@@ rtl/sdn_queue.sv @@
// Short word queue between front and back, in flip-flops.
// Depends on sdn_pkg.
module sdn_queue #(
    parameter int DEPTH = sdn_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sdn_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output sdn_pkg::t_job o_data
);
    import sdn_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

endmodule

@@ rtl/sdn_sqrt.sv @@
// Pipelined integer square root, one root bit per stage.
// Depends on sdn_pkg.
module sdn_sqrt (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [sdn_pkg::SUM_W-1:0]    i_rad,
    output logic [sdn_pkg::ROOT_W-1:0]   o_root,
    output logic [sdn_pkg::REM_W-1:0]    o_rem
);
    import sdn_pkg::*;

    localparam int T_W = REM_W + 2;

    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SUM_W-1:0]  r_rad  [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        logic [REM_W-1:0]  s_rem;
        logic [ROOT_W-1:0] s_root;
        logic [SUM_W-1:0]  s_rad;
        logic [T_W-1:0]    t;
        logic [T_W-1:0]    trial;

        if (j == 0) begin : g_first
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_rad  = i_rad;
        end else begin : g_next
            assign s_rem  = r_rem[j-1];
            assign s_root = r_root[j-1];
            assign s_rad  = r_rad[j-1];
        end

        assign t     = {s_rem, s_rad[SUM_W-1:SUM_W-2]};
        assign trial = T_W'({s_root, 2'b01});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[j] <= {s_rad[SUM_W-3:0], 2'b00};
                if (t >= trial) begin
                    r_rem[j]  <= REM_W'(t - trial);
                    r_root[j] <= {s_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[j]  <= REM_W'(t);
                    r_root[j] <= {s_root[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];
    assign o_rem  = r_rem[ROOT_W-1];

endmodule

@@ rtl/sdn_div.sv @@
// Pipelined restoring divider for one normal component, one quotient bit per stage.
// Depends on sdn_pkg.
module sdn_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [sdn_pkg::MAG_W-1:0]   i_mag,
    input  logic [sdn_pkg::LEN_W-1:0]   i_len,
    output logic [sdn_pkg::Q_W-1:0]     o_q
);
    import sdn_pkg::*;

    localparam int CMP_W = NUM_W + 1;

    logic [NUM_W-1:0] r_r [Q_W];
    logic [DEN_W-1:0] r_d [Q_W];
    logic [Q_W-1:0]   r_q [Q_W];

    for (genvar j = 0; j < Q_W; j++) begin : g_stage
        localparam int B = Q_W - 1 - j;
        logic [NUM_W-1:0] s_r;
        logic [DEN_W-1:0] s_d;
        logic [Q_W-1:0]   s_q;
        logic [CMP_W-1:0] dsh;

        if (j == 0) begin : g_first
            // (mag * 2^15 + len) / (2 * len), rounds half up
            assign s_r = NUM_W'({i_mag, {(Q_W){1'b0}}}) + NUM_W'(i_len);
            assign s_d = {i_len, 1'b0};
            assign s_q = '0;
        end else begin : g_next
            assign s_r = r_r[j-1];
            assign s_d = r_d[j-1];
            assign s_q = r_q[j-1];
        end

        assign dsh = CMP_W'(s_d) << B;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d[j] <= s_d;
                if (CMP_W'(s_r) >= dsh) begin
                    r_r[j] <= NUM_W'(CMP_W'(s_r) - dsh);
                    r_q[j] <= s_q | (Q_W'(1) << B);
                end else begin
                    r_r[j] <= s_r;
                    r_q[j] <= s_q;
                end
            end
        end
    end

    assign o_q = r_q[Q_W-1];

endmodule

@@ rtl/sdn_back.sv @@
// Back end: length and unit direction for edge and corner queries, output register.
// Depends on sdn_pkg, sdn_sqrt and sdn_div.
module sdn_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  sdn_pkg::t_job        i_job,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output sdn_pkg::t_out_word   o_word
);
    import sdn_pkg::*;

    logic                   en;
    logic                   r_s1_vld, r_s2_vld, r_s3_vld, r_out_vld;
    t_job                   r_s1_job, r_s2_job, r_s3_job;
    logic [SQ_W-1:0]        r_sq [3];
    logic [SUM_W-1:0]       r_sum;
    logic [ROOT_W-1:0]      root;
    logic [REM_W-1:0]       rem;
    logic [LEN_W-1:0]       r_len;
    logic                   r_dl1_vld [SQRT_LAT];
    t_job                   r_dl1_job [SQRT_LAT];
    logic                   r_dl2_vld [DIV_LAT];
    t_job                   r_dl2_job [DIV_LAT];
    logic [LEN_W-1:0]       r_dl2_len [DIV_LAT];
    logic [Q_W-1:0]         q [3];
    t_out_word              r_word;
    t_out_word              n_word;

    assign en      = !(r_out_vld && i_stall);
    assign o_pop   = en && i_valid;
    assign o_valid = r_out_vld;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int j = 0; j < SQRT_LAT; j++) r_dl1_vld[j] <= 1'b0;
            for (int j = 0; j < DIV_LAT; j++)  r_dl2_vld[j] <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_valid;
            r_s2_vld <= r_s1_vld;
            r_dl1_vld[0] <= r_s2_vld;
            for (int j = 1; j < SQRT_LAT; j++) r_dl1_vld[j] <= r_dl1_vld[j-1];
            r_s3_vld <= r_dl1_vld[SQRT_LAT-1];
            r_dl2_vld[0] <= r_s3_vld;
            for (int j = 1; j < DIV_LAT; j++) r_dl2_vld[j] <= r_dl2_vld[j-1];
            r_out_vld <= r_dl2_vld[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_job <= i_job;
            for (int a = 0; a < 3; a++) begin
                r_sq[a] <= SQ_W'(i_job.mag[a]) * SQ_W'(i_job.mag[a]);
            end
            r_s2_job <= r_s1_job;
            r_sum    <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
            r_dl1_job[0] <= r_s2_job;
            for (int j = 1; j < SQRT_LAT; j++) r_dl1_job[j] <= r_dl1_job[j-1];
            // round to nearest: bump when the remainder exceeds the root
            r_s3_job <= r_dl1_job[SQRT_LAT-1];
            r_len    <= LEN_W'(root) + LEN_W'(REM_W'(rem) > REM_W'(root));
            r_dl2_job[0] <= r_s3_job;
            r_dl2_len[0] <= r_len;
            for (int j = 1; j < DIV_LAT; j++) begin
                r_dl2_job[j] <= r_dl2_job[j-1];
                r_dl2_len[j] <= r_dl2_len[j-1];
            end
            r_word <= n_word;
        end
    end

    sdn_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_sum),
        .o_root (root),
        .o_rem  (rem)
    );

    for (genvar a = 0; a < 3; a++) begin : g_lane
        sdn_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_mag (r_s3_job.mag[a]),
            .i_len (r_len),
            .o_q   (q[a])
        );
    end

    always_comb begin
        t_job                   jb;
        logic [LEN_W-1:0]       ln;
        logic [2:0][NRM_W-1:0]  nv;
        logic signed [CLR_W:0]  sd;

        jb = r_dl2_job[DIV_LAT-1];
        ln = r_dl2_len[DIV_LAT-1];
        nv = jb.nrm;
        sd = '0;
        n_word = '0;
        n_word.inside_res = jb.in_box;
        n_word.region     = jb.region;
        n_word.distance   = jb.dval;
        if (jb.region == REG_EDGE) begin
            sd = $signed((CLR_W+1)'(ln));
            if (jb.ksat) begin
                n_word.distance = jb.sneg ? 32'h7FFF_FFFF : 32'h8000_0000;
            end else begin
                n_word.distance = sat_dist(jb.sneg ? sd : -sd);
            end
            for (int a = 0; a < 3; a++) begin
                nv[a] = (jb.neg[a] ^ jb.sneg) ? NRM_W'(q[a]) : -NRM_W'(q[a]);
            end
        end
        n_word.normal_x = nv[0];
        n_word.normal_y = nv[1];
        n_word.normal_z = nv[2];
    end

endmodule

@@ rtl/sdn_checker.sv @@
// Port-level checks for the box signed-distance unit, bound to the top level.
// Depends on sdn_pkg and aabb_signed_distance_normal_unit.
module sdn_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_out_valid,
    input  logic               i_out_stall,
    input  sdn_pkg::t_out_word o_out_word
);
    import sdn_pkg::*;

    // Hold a stalled result word.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result word changed");

    a_inside_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.inside_res == (o_out_word.region == REG_INSIDE)))
        else $error("inside flag disagrees with region");

    a_face_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.region == REG_INSIDE || o_out_word.region == REG_FACE)
        |-> $countones({o_out_word.normal_x != 0, o_out_word.normal_y != 0,
                        o_out_word.normal_z != 0}) == 1)
        else $error("face normal not on a single axis");

    a_region_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.region != 2'd3)
        else $error("unused region code");

endmodule

bind aabb_signed_distance_normal_unit sdn_checker u_sdn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

@@ test/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for aabb_signed_distance_normal_unit: a driver feeds query words, a
// monitor checks each result word against a local signed-distance predictor. Depends on sdn_pkg.
module tb;
    import sdn_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_word   i_in_word = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_word  o_out_word;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [POS_W-1:0]     i_cfg_data = '0;

    aabb_signed_distance_normal_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_word(o_out_word),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Local copy of the box and sign registers, updated on each accepted write.
    longint    box_lo[3];
    longint    box_hi[3];
    bit        sign_neg;

    t_in_word  query_q[$];      // query words waiting to be offered
    t_out_word answer_q[$];     // predicted result words, oldest first
    int        n_errors = 0;
    int        n_answers = 0;
    int        cyc = 0;
    int        hold_left = 0;
    bit        held_once = 0;

    // Predict one result word from a query, using the current box and sign.
    function automatic t_out_word predict_sdf(t_in_word w);
        t_out_word         r;
        longint            p[3];
        longint            clr[6];
        longint            sg, rad, d;
        longint            nrm[3];
        longint unsigned   mag[3];
        longint unsigned   sum, len, rem, maxm, bitv, v, q;
        bit                ng[3];
        bit [5:0]          om;
        int                cnt, last, best, k, rg;
        bit                ins;
        sg   = sign_neg ? -1 : 1;
        rad  = longint'(w.radius);
        p[0] = longint'(w.pos_x);
        p[1] = longint'(w.pos_y);
        p[2] = longint'(w.pos_z);
        om = '0; cnt = 0; last = 0;
        nrm[0] = 0; nrm[1] = 0; nrm[2] = 0;
        for (int a = 0; a < 3; a++) begin
            clr[2*a]   = (p[a] - rad) - box_lo[a];
            clr[2*a+1] = box_hi[a] - (p[a] + rad);
        end
        for (int i = 0; i < 6; i++) begin
            if (clr[i] < 0) begin
                om[i] = 1'b1; cnt++; last = i;
            end
        end
        if (om == 0) begin
            // Inside: smallest clearance, later face wins a tie.
            best = 0;
            for (int i = 1; i < 6; i++) if (clr[i] <= clr[best]) best = i;
            d = sg * clr[best];
            nrm[best/2] = sg * ((best % 2) ? -16384 : 16384);
            ins = 1; rg = REG_INSIDE;
        end else if (cnt == 1) begin
            d = sg * clr[last];
            nrm[last/2] = sg * ((last % 2) ? -16384 : 16384);
            ins = 0; rg = REG_FACE;
        end else begin
            // Edge or corner: length and direction of the overshoot vector.
            maxm = 0;
            for (int a = 0; a < 3; a++) begin
                mag[a] = 0; ng[a] = 0;
                if (om[2*a]) begin
                    mag[a] = longint'(-clr[2*a]); ng[a] = 1;
                end else if (om[2*a+1]) begin
                    mag[a] = longint'(-clr[2*a+1]);
                end
                if (mag[a] > maxm) maxm = mag[a];
            end
            k = 0;
            while (k < 2 && (maxm >> k) >= 64'd2147483648) k++;
            sum = 0;
            for (int a = 0; a < 3; a++) begin
                mag[a] = mag[a] >> k;
                sum += mag[a] * mag[a];
            end
            v = sum; len = 0; bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0) begin
                if (v >= len + bitv) begin
                    v -= len + bitv;
                    len = (len >> 1) + bitv;
                end else begin
                    len >>= 1;
                end
                bitv >>= 2;
            end
            rem = sum - len * len;
            if (rem > len) len++;
            if (k == 0) d = -sg * longint'(len);
            else d = (sg > 0) ? -64'sd2147483648 : 64'sd2147483647;
            for (int a = 0; a < 3; a++) begin
                q = (mag[a] * 32768 + len) / (2 * len);
                nrm[a] = ng[a] ? sg * longint'(q) : -sg * longint'(q);
            end
            ins = 0; rg = REG_EDGE;
        end
        if (d > 64'sd2147483647) d = 64'sd2147483647;
        if (d < -64'sd2147483648) d = -64'sd2147483648;
        r.distance   = d[31:0];
        r.normal_x   = nrm[0][15:0];
        r.normal_y   = nrm[1][15:0];
        r.normal_z   = nrm[2][15:0];
        r.inside_res = ins;
        r.region     = rg[1:0];
        return r;
    endfunction

    // Quiet window: no idling on either side.
    function automatic bit idle_now();
        return !(cyc >= 1500 && cyc < 2500) && ($urandom_range(0, 99) < 7);
    endfunction

    // Driver: push a prediction on every accepted word, hold a stalled word.
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                answer_q.push_back(predict_sdf(i_in_word));
                void'(query_q.pop_front());
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (query_q.size() > 0 && !idle_now()) begin
                    i_in_valid <= 1'b1;
                    i_in_word  <= query_q[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Hold off once for a long stretch so the queue fills and input stalls.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
            end else if (!held_once && n_answers >= 150) begin
                held_once <= 1'b1;
                hold_left <= 300;
            end
        end
    end

    // Monitor: check the oldest prediction, then pick next cycle's stall.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (answer_q.size() == 0) begin
                    $error("result word with no prediction waiting");
                    n_errors++;
                end else begin
                    t_out_word e;
                    e = answer_q.pop_front();
                    if (o_out_word.distance !== e.distance) begin
                        $error("distance exp %0d got %0d", e.distance, o_out_word.distance);
                        n_errors++;
                    end
                    if (o_out_word.normal_x !== e.normal_x) begin
                        $error("normal_x exp %0d got %0d", e.normal_x, o_out_word.normal_x);
                        n_errors++;
                    end
                    if (o_out_word.normal_y !== e.normal_y) begin
                        $error("normal_y exp %0d got %0d", e.normal_y, o_out_word.normal_y);
                        n_errors++;
                    end
                    if (o_out_word.normal_z !== e.normal_z) begin
                        $error("normal_z exp %0d got %0d", e.normal_z, o_out_word.normal_z);
                        n_errors++;
                    end
                    if (o_out_word.inside_res !== e.inside_res) begin
                        $error("inside_res exp %0d got %0d", e.inside_res,
                               o_out_word.inside_res);
                        n_errors++;
                    end
                    if (o_out_word.region !== e.region) begin
                        $error("region exp %0d got %0d", e.region, o_out_word.region);
                        n_errors++;
                    end
                end
                n_answers++;
            end
            i_out_stall <= (hold_left > 0) || idle_now();
        end
    end

    // Write one register over the config channel and mirror it locally.
    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_MIN_X, CFG_MIN_Y, CFG_MIN_Z: box_lo[idx] = longint'($signed(val));
            CFG_MAX_X: box_hi[0] = longint'($signed(val));
            CFG_MAX_Y: box_hi[1] = longint'($signed(val));
            CFG_MAX_Z: box_hi[2] = longint'($signed(val));
            CFG_SIGN:  sign_neg = val[0];
            default: ;
        endcase
    endtask

    task automatic set_box(logic [31:0] lo, logic [31:0] hi, bit sgn);
        write_reg(CFG_MIN_X, lo);
        write_reg(CFG_MIN_Y, lo);
        write_reg(CFG_MIN_Z, lo);
        write_reg(CFG_MAX_X, hi);
        write_reg(CFG_MAX_Y, hi);
        write_reg(CFG_MAX_Z, hi);
        write_reg(CFG_SIGN, {31'd0, sgn});
    endtask

    task automatic add_query(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [30:0] r);
        t_in_word w;
        w.pos_x = x; w.pos_y = y; w.pos_z = z; w.radius = r;
        query_q.push_back(w);
    endtask

    // Drop random queries: most near the box faces, some anywhere.
    task automatic add_random(int n);
        t_in_word w;
        longint   span, c;
        logic [31:0] pv[3];
        logic [30:0] rv;
        for (int i = 0; i < n; i++) begin
            for (int a = 0; a < 3; a++) begin
                if ($urandom_range(0, 9) < 2) begin
                    pv[a] = $urandom;
                end else begin
                    span = box_hi[a] - box_lo[a];
                    if (span <= 0 || span > 64'd16777216) span = 131072;
                    c = box_lo[a] - span / 2 + longint'($urandom_range(0, 2 * span));
                    pv[a] = c[31:0];
                end
            end
            case ($urandom_range(0, 9))
                0: rv = '0;
                1: rv = $urandom;
                default: rv = $urandom_range(0, 32768);
            endcase
            w.pos_x = pv[0]; w.pos_y = pv[1]; w.pos_z = pv[2]; w.radius = rv;
            query_q.push_back(w);
        end
    endtask

    // Pause the sender until every prediction has been matched.
    task automatic drain();
        while (query_q.size() > 0 || answer_q.size() > 0 || i_in_valid) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        for (int a = 0; a < 3; a++) begin
            box_lo[a] = 0; box_hi[a] = 65536;
        end
        sign_neg = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: unit box from reset.
        add_query(32'd32768, 32'd32768, 32'd32768, 31'd0);      // center, all faces tie
        add_query(32'd100, 32'd40000, 32'd30000, 31'd0);        // inside, near x-min
        add_query(32'd0, 32'd32768, 32'd65536, 31'd0);          // on faces exactly
        add_query(32'd32768, 32'd32768, 32'd32768, 31'd16000);  // sphere inside
        add_query(32'd90000, 32'd32768, 32'd32768, 31'd0);      // past x-max face
        add_query(32'hFFFF_0000, 32'd32768, 32'd32768, 31'd0);  // past x-min face
        add_query(32'd90000, 32'd90000, 32'd32768, 31'd0);      // edge
        add_query(32'hFFFF_0000, 32'd90000, 32'hFFFE_0000, 31'd0);  // corner
        add_query(32'd32768, 32'd32768, 32'd32768, 31'd131072); // both sides of each axis
        add_query(32'd32768, 32'd32768, 32'd90000, 31'd40000);  // x, y out both sides, z past max
        add_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        add_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
        add_query(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 31'd0);
        add_query(32'd0, 32'd0, 32'd0, 31'h7FFF_FFFF);
        add_query(32'h7FFF_FFFF, 32'd32768, 32'd32768, 31'd0);
        add_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd32768, 31'd1);
        add_random(300);
        drain();

        // Sign flipped, random box.
        set_box($urandom_range(0, 32'h0004_0000) - 32'h0002_0000,
                32'h0003_0000 + $urandom_range(0, 32'h0004_0000), 1'b1);
        add_query(32'd32768, 32'd32768, 32'd32768, 31'd0);
        add_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
        add_random(150);
        drain();

        // Widest box.
        set_box(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        add_query(32'd0, 32'd0, 32'd0, 31'h7FFF_FFFF);
        add_query(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 31'd0);
        add_random(60);
        drain();

        // Degenerate box (min above max), sign negative.
        set_box(32'h0002_0000, 32'h0001_0000, 1'b1);
        add_random(60);
        drain();

        // Per-axis box edits, sign positive.
        write_reg(CFG_MIN_X, 32'hFFFF_8000);
        write_reg(CFG_MAX_Y, 32'h0010_0000);
        write_reg(CFG_MIN_Z, 32'hFFF0_0000);
        write_reg(CFG_SIGN, 32'd0);
        add_random(130);
        drain();

        repeat (60) @(posedge i_clk);
        if (n_errors == 0 && answer_q.size() == 0) begin
            $display("[aabb_signed_distance_normal_unit] OK");
        end else begin
            $display("[aabb_signed_distance_normal_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("[aabb_signed_distance_normal_unit] ERROR");
        $finish;
    end

endmodule
